// ===== hw/rtl/telemetry_sentence_crc_serializer_macros.svh =====
// assertion helpers for the sentence serializer
`ifndef TELEMETRY_SENTENCE_CRC_SERIALIZER_MACROS_SVH
`define TELEMETRY_SENTENCE_CRC_SERIALIZER_MACROS_SVH

// checked only outside reset
`define TSCS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define TSCS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hw/rtl/tscs_pkg.sv =====
package tscs_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
  localparam logic [7:0] CHAR_STAR    = 8'h2A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] ASCII_ZERO   = 8'h30;
  localparam logic [7:0] ASCII_LETTER = 8'h37;

  localparam logic [7:0] MARK_RESET  = 8'd110;
  localparam logic [7:0] SPACE_RESET = 8'd100;

  // configuration register indexes
  localparam logic [1:0] REG_MARK  = 2'd0;
  localparam logic [1:0] REG_SPACE = 2'd1;

  // which character of a job is on the line
  typedef enum logic [2:0] {
    CH_USER = 3'd0,
    CH_STAR = 3'd1,
    CH_HEX3 = 3'd2,
    CH_HEX2 = 3'd3,
    CH_HEX1 = 3'd4,
    CH_HEX0 = 3'd5,
    CH_NL   = 3'd6
  } tscs_char_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_sentence;
  } tscs_in_t;

  typedef struct packed {
    logic       line_bit;
    logic [7:0] drive_level;
    logic       last_bit;
  } tscs_out_t;

  // one classified character handed from front to back
  typedef struct packed {
    logic [7:0]  char_code;
    logic        trailer;
    logic [15:0] crc;
  } tscs_job_t;

  function automatic logic [15:0] crc16_add(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] r;
    r = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    return (nib < 4'd10) ? (ASCII_ZERO + wide) : (ASCII_LETTER + wide);
  endfunction

endpackage

// ===== hw/rtl/tscs_front.sv =====
module tscs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  tscs_pkg::tscs_in_t in_i,
  output tscs_pkg::tscs_job_t job_o
);
  import tscs_pkg::*;

  logic [15:0] crc_q, crc_d;
  logic [15:0] crc_new;

  // dollar signs pass through without touching the checksum
  always_comb begin
    crc_new = (in_i.char_code != CHAR_DOLLAR) ? crc16_add(crc_q, in_i.char_code) : crc_q;
    crc_d   = crc_q;
    if (accept_i) begin
      crc_d = in_i.end_of_sentence ? CRC_INIT : crc_new;
    end
  end

  assign job_o.char_code = in_i.char_code;
  assign job_o.trailer   = in_i.end_of_sentence;
  assign job_o.crc       = crc_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
    end else begin
      crc_q <= crc_d;
    end
  end

endmodule

// ===== hw/rtl/tscs_queue.sv =====
module tscs_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tscs_pkg::tscs_job_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output tscs_pkg::tscs_job_t data_o
);
  import tscs_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  tscs_job_t           slot_q [DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== hw/rtl/tscs_back.sv =====
module tscs_back #(
  parameter int unsigned DATA_BITS = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  tscs_pkg::tscs_job_t job_i,
  output logic                job_pop_o,
  input  logic [7:0]          mark_level_i,
  input  logic [7:0]          space_level_i,
  output logic                out_valid_o,
  input  logic                out_pop_i,
  output tscs_pkg::tscs_out_t out_o
);
  import tscs_pkg::*;

  localparam int unsigned BitW = $clog2(DATA_BITS + 2);
  localparam logic [BitW-1:0] StopIdx = BitW'(DATA_BITS + 1);

  tscs_char_e      char_q, char_d;
  logic [BitW-1:0] bit_idx_q, bit_idx_d;
  logic [BitW-1:0] data_idx;
  logic            out_valid_q, out_valid_d;
  logic            out_bit_q, out_bit_d;
  logic            out_last_q, out_last_d;
  logic [7:0]      cur_char;
  logic [3:0]      nibble;
  logic            cur_bit;
  logic            char_done;
  logic            job_done;
  logic            step;

  // output register frees up when empty or being taken this cycle
  assign step = job_valid_i && (!out_valid_q || out_pop_i);

  always_comb begin
    nibble   = job_i.crc[3:0];
    cur_char = job_i.char_code;
    unique case (char_q)
      CH_USER: cur_char = job_i.char_code;
      CH_STAR: cur_char = CHAR_STAR;
      CH_HEX3, CH_HEX2, CH_HEX1, CH_HEX0: begin
        unique case (char_q)
          CH_HEX3: nibble = job_i.crc[15:12];
          CH_HEX2: nibble = job_i.crc[11:8];
          CH_HEX1: nibble = job_i.crc[7:4];
          default: nibble = job_i.crc[3:0];
        endcase
        cur_char = hex_ascii(nibble);
      end
      CH_NL:   cur_char = CHAR_NEWLINE;
      default: cur_char = CHAR_NEWLINE;
    endcase
  end

  // start bit, data bits lsb first, stop bit
  assign data_idx = bit_idx_q - 1'b1;
  always_comb begin
    if (bit_idx_q == '0) begin
      cur_bit = 1'b0;
    end else if (bit_idx_q == StopIdx) begin
      cur_bit = 1'b1;
    end else begin
      cur_bit = cur_char[data_idx[2:0]];
    end
  end

  assign char_done = (bit_idx_q == StopIdx);
  assign job_done  = char_done && ((char_q == CH_NL) || (char_q == CH_USER && !job_i.trailer));
  assign job_pop_o = step && job_done;

  always_comb begin
    char_d      = char_q;
    bit_idx_d   = bit_idx_q;
    out_valid_d = out_valid_q;
    out_bit_d   = out_bit_q;
    out_last_d  = out_last_q;
    if (step) begin
      out_valid_d = 1'b1;
      out_bit_d   = cur_bit;
      out_last_d  = job_done;
      if (char_done) begin
        bit_idx_d = '0;
        char_d    = job_done ? CH_USER : tscs_char_e'(char_q + 3'd1);
      end else begin
        bit_idx_d = bit_idx_q + 1'b1;
      end
    end else if (out_pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_q      <= CH_USER;
      bit_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      char_q      <= char_d;
      bit_idx_q   <= bit_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_bit_q  <= out_bit_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o       = out_valid_q;
  assign out_o.line_bit    = out_bit_q;
  assign out_o.drive_level = out_bit_q ? mark_level_i : space_level_i;
  assign out_o.last_bit    = out_last_q;

endmodule

// ===== hw/rtl/telemetry_sentence_crc_serializer.sv =====
// channel   direction  handshake            payload
// input     in         push / full          in_i  (char_code, end_of_sentence)
// result    out        empty / pop          out_o (line_bit, drive_level, last_bit)
// config    in         cfg_valid_i / ready  cfg_index_i, cfg_data_i
//
// one line bit per cycle from the back serializer while a job is queued and
// the result register is free or popped: DATA_BITS+2 bits per character,
// seven characters with the checksum trailer. the front takes a character
// while the job queue has room, even as earlier ones are still shifted out.
// reset sets the crc to 0xFFFF and the levels to 110 / 100; no clearing pass.
// a stall on pop holds the result register and, once the queue fills, push.
module telemetry_sentence_crc_serializer #(
  parameter int unsigned DATA_BITS = 7,
  parameter int unsigned JOB_DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  tscs_pkg::tscs_in_t  in_i,
  output logic                empty,
  input  logic                pop,
  output tscs_pkg::tscs_out_t out_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i
);
  import tscs_pkg::*;

  `include "telemetry_sentence_crc_serializer_macros.svh"

  logic       in_xfer;
  tscs_job_t  front_job;
  tscs_job_t  head_job;
  logic       head_valid;
  logic       head_pop;
  logic       out_valid;
  logic [7:0] mark_q, mark_d;
  logic [7:0] space_q, space_d;

  assign in_xfer     = push && !full;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    mark_d  = mark_q;
    space_d = space_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MARK:  mark_d  = cfg_data_i;
        REG_SPACE: space_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q  <= MARK_RESET;
      space_q <= SPACE_RESET;
    end else begin
      mark_q  <= mark_d;
      space_q <= space_d;
    end
  end

  tscs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_xfer),
    .in_i     (in_i),
    .job_o    (front_job)
  );

  tscs_queue #(
    .DEPTH (JOB_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_xfer),
    .data_i  (front_job),
    .full_o  (full),
    .pop_i   (head_pop),
    .valid_o (head_valid),
    .data_o  (head_job)
  );

  tscs_back #(
    .DATA_BITS (DATA_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (head_valid),
    .job_i         (head_job),
    .job_pop_o     (head_pop),
    .mark_level_i  (mark_q),
    .space_level_i (space_q),
    .out_valid_o   (out_valid),
    .out_pop_i     (pop),
    .out_o         (out_o)
  );

  assign empty = !out_valid;

  `TSCS_ASSERT(a_push_fills_queue, in_xfer |=> head_valid, "queue empty after a character transfer")
  `TSCS_ASSERT(a_retire_marks_last, head_pop |=> (!empty && out_o.last_bit), "job retired without its last bit")
  `TSCS_ASSERT(a_last_only_with_job, (head_valid && !head_pop && !empty && out_o.last_bit && !pop) |=> out_o.last_bit, "last bit lost while stalled")
  `TSCS_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> (empty && !full), "not idle in reset")

endmodule

// ===== verif/tb_telemetry_sentence_crc_serializer.sv =====
module tb_telemetry_sentence_crc_serializer;
  import tscs_pkg::*;

  localparam int unsigned IDLE_LIMIT      = 3000;
  localparam int unsigned SETTLE_CYCLES   = 20;
  localparam int unsigned CHAR_CYCLES     = 9;
  localparam int unsigned ITEMS_PER_PHASE = 64;
  localparam int unsigned NUM_PHASES      = 5;
  localparam int unsigned REPORT_LIMIT    = 50;

  typedef struct packed {
    logic [7:0]  code;
    logic        eos;
    logic        frame_known;
    logic [8:0]  frame;
    logic        crc_known;
    logic [15:0] crc;
  } char_row_t;

  typedef enum logic [1:0] {
    RX_STREAM,
    RX_CADENCE,
    RX_COIN,
    RX_CHOKE
  } rx_mode_e;

  logic       clk_i       = 1'b0;
  logic       rst_ni;
  logic       push        = 1'b0;
  logic       full;
  tscs_in_t   in_i        = '0;
  logic       empty;
  logic       pop         = 1'b0;
  tscs_out_t  out_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = REG_MARK;
  logic [7:0] cfg_data_i  = '0;

  // predictor state
  logic [15:0] crc_acc   = CRC_INIT;
  logic [7:0]  mark_lvl  = MARK_RESET;
  logic [7:0]  space_lvl = SPACE_RESET;
  tscs_out_t   pending_bits[$];

  int unsigned err_cnt       = 0;
  int unsigned bits_checked  = 0;
  int unsigned chars_sent    = 0;
  int unsigned trailers_sent = 0;
  int unsigned settings_used = 1;
  int unsigned burst_left    = 0;
  int unsigned idle_cycles   = 0;
  int unsigned rx_mode_left  = 0;
  int unsigned rx_phase      = 0;
  rx_mode_e    rx_mode       = RX_STREAM;

  // frame is in line order: bit 0 start, bits 1..7 data lsb first, bit 8 stop
  char_row_t dir_rows [0:20] = '{
    // right after reset: lone dollar closes the sentence, checksum untouched
    '{CHAR_DOLLAR, 1'b1, 1'b1, 9'b1_0100100_0, 1'b1, 16'hFFFF},
    '{8'h00, 1'b0, 1'b1, 9'b1_0000000_0, 1'b0, 16'h0000},
    '{8'hFF, 1'b0, 1'b1, 9'b1_1111111_0, 1'b0, 16'h0000},
    // top bit is counted in the checksum but never reaches the line
    '{8'h80, 1'b0, 1'b1, 9'b1_0000000_0, 1'b0, 16'h0000},
    '{8'h55, 1'b0, 1'b1, 9'b1_1010101_0, 1'b0, 16'h0000},
    '{8'hAA, 1'b0, 1'b1, 9'b1_0101010_0, 1'b0, 16'h0000},
    '{8'h7F, 1'b1, 1'b1, 9'b1_1111111_0, 1'b0, 16'h0000},
    // standard check string, ccitt-false value of "123456789" is 0x29b1
    '{CHAR_DOLLAR, 1'b0, 1'b0, 9'h000, 1'b0, 16'h0000},
    '{8'h31, 1'b0, 1'b0, 9'h000, 1'b0, 16'h0000},
    '{8'h32, 1'b0, 1'b0, 9'h000, 1'b0, 16'h0000},
    '{8'h33, 1'b0, 1'b0, 9'h000, 1'b0, 16'h0000},
    '{8'h34, 1'b0, 1'b0, 9'h000, 1'b0, 16'h0000},
    '{8'h35, 1'b0, 1'b0, 9'h000, 1'b0, 16'h0000},
    '{8'h36, 1'b0, 1'b0, 9'h000, 1'b0, 16'h0000},
    '{8'h37, 1'b0, 1'b0, 9'h000, 1'b0, 16'h0000},
    '{8'h38, 1'b0, 1'b0, 9'h000, 1'b0, 16'h0000},
    '{8'h39, 1'b1, 1'b0, 9'h000, 1'b1, 16'h29B1},
    // dollar inside a sentence is skipped by the checksum
    '{8'h41, 1'b0, 1'b0, 9'h000, 1'b0, 16'h0000},
    '{CHAR_DOLLAR, 1'b0, 1'b0, 9'h000, 1'b0, 16'h0000},
    '{8'h7A, 1'b0, 1'b0, 9'h000, 1'b0, 16'h0000},
    '{8'hA5, 1'b1, 1'b0, 9'h000, 1'b0, 16'h0000}
  };

  telemetry_sentence_crc_serializer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_i        (in_i),
    .empty       (empty),
    .pop         (pop),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] code);
    logic [15:0] acc;
    acc = crc ^ {code, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (acc[15]) begin
        acc = {acc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        acc = {acc[14:0], 1'b0};
      end
    end
    return acc;
  endfunction

  function automatic logic [8:0] frame_of(input logic [7:0] code);
    return {1'b1, code[6:0], 1'b0};
  endfunction

  // uppercase hex digit: '0' is 0x30, 'A' is 0x41
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h41 + {4'h0, nib} - 8'd10);
  endfunction

  function automatic void queue_frame(input logic [8:0] frame, input logic closes);
    tscs_out_t bit_exp;
    for (int k = 0; k < 9; k++) begin
      bit_exp.line_bit    = frame[k];
      bit_exp.drive_level = frame[k] ? mark_lvl : space_lvl;
      bit_exp.last_bit    = closes && (k == 8);
      pending_bits.push_back(bit_exp);
    end
  endfunction

  function automatic void predict_char(input char_row_t row);
    logic [15:0] snap;
    if (row.code != CHAR_DOLLAR) begin
      crc_acc = crc_update(crc_acc, row.code);
    end
    queue_frame(row.frame_known ? row.frame : frame_of(row.code), !row.eos);
    chars_sent++;
    if (row.eos) begin
      snap = row.crc_known ? row.crc : crc_acc;
      queue_frame(frame_of(CHAR_STAR), 1'b0);
      for (int d = 3; d >= 0; d--) begin
        queue_frame(frame_of(hex_char(snap[4*d +: 4])), 1'b0);
      end
      queue_frame(frame_of(CHAR_NEWLINE), 1'b1);
      crc_acc = CRC_INIT;
      trailers_sent++;
    end
  endfunction

  function automatic char_row_t make_item(input logic [7:0] code, input logic eos);
    char_row_t row;
    row      = '0;
    row.code = code;
    row.eos  = eos;
    return row;
  endfunction

  task automatic send_row(input char_row_t row);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    push <= 1'b1;
    in_i <= '{char_code: row.code, end_of_sentence: row.eos};
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_char(row);
  endtask

  task automatic send_sentence();
    int unsigned kind;
    int unsigned body_len;
    logic [7:0]  code;
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      // well formed: one or two dollars, printable body, last char closes it
      repeat ($urandom_range(1, 2)) send_row(make_item(CHAR_DOLLAR, 1'b0));
      body_len = $urandom_range(1, 14);
      for (int i = 0; i < body_len; i++) begin
        code = 8'($urandom_range(32, 126));
        send_row(make_item(code, i == body_len - 1));
      end
    end else if (kind == 7) begin
      repeat ($urandom_range(1, 6)) begin
        send_row(make_item(8'($urandom), $urandom_range(0, 3) == 0));
      end
    end else if (kind == 8) begin
      // broken: stray dollars, control and high-bit bytes mixed with printable ones
      body_len = $urandom_range(2, 10);
      for (int i = 0; i < body_len; i++) begin
        case ($urandom_range(0, 3))
          0: code = CHAR_DOLLAR;
          1: code = 8'($urandom_range(0, 31));
          2: code = 8'($urandom_range(128, 255));
          default: code = 8'($urandom_range(32, 126));
        endcase
        send_row(make_item(code, i == body_len - 1));
      end
    end else begin
      code = $urandom_range(0, 1) ? CHAR_DOLLAR : 8'($urandom);
      send_row(make_item(code, 1'b1));
    end
  endtask

  task automatic drain_line();
    push <= 1'b0;
    while (pending_bits.size() != 0) @(posedge clk_i);
    repeat (CHAR_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_MARK) begin
      mark_lvl = value;
    end else begin
      space_lvl = value;
    end
  endtask

  task automatic set_levels(input logic [7:0] mark, input logic [7:0] space);
    drain_line();
    write_reg(REG_MARK, mark);
    write_reg(REG_SPACE, space);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  task automatic flag_mismatch(input string field, input int unsigned want, input int unsigned got);
    err_cnt++;
    if (err_cnt <= REPORT_LIMIT) begin
      $display("%0t mismatch on %s: expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  // receiver stall pattern, picks a new random mode and run length when the current run ends
  always @(posedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(16, 96);
    end
    rx_mode_left--;
    rx_phase++;
    case (rx_mode)
      RX_STREAM:  pop <= 1'b1;
      RX_CADENCE: pop <= (rx_phase % 4) != 3;
      RX_COIN:    pop <= 1'($urandom_range(0, 1));
      default:    pop <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    tscs_out_t want;
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t watchdog: no transfer for %0d cycles, %0d bits outstanding",
                 $time, idle_cycles, pending_bits.size());
        $display("status: fail");
        $finish;
      end
      if (pop && !empty) begin
        bits_checked++;
        if (pending_bits.size() == 0) begin
          flag_mismatch("unexpected line bit", 0, out_o);
        end else begin
          want = pending_bits.pop_front();
          if (out_o.line_bit !== want.line_bit) begin
            flag_mismatch("line_bit", want.line_bit, out_o.line_bit);
          end
          if (out_o.drive_level !== want.drive_level) begin
            flag_mismatch("drive_level", want.drive_level, out_o.drive_level);
          end
          if (out_o.last_bit !== want.last_bit) begin
            flag_mismatch("last_bit", want.last_bit, out_o.last_bit);
          end
        end
      end
    end
  end

  initial begin
    int unsigned target;
    // a real falling edge so the asynchronous reset takes effect at time zero
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      send_row(dir_rows[i]);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        1: set_levels(8'hFF, 8'h00);
        2: set_levels(8'h00, 8'hFF);
        3: set_levels(8'($urandom), 8'($urandom));
        4: set_levels(MARK_RESET, SPACE_RESET);
        default: ;
      endcase
      target = chars_sent + ITEMS_PER_PHASE;
      while (chars_sent < target) send_sentence();
    end

    drain_line();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("sent %0d characters, %0d with checksum trailer, over %0d level settings",
             chars_sent, trailers_sent, settings_used);
    $display("checked %0d line bits, %0d mismatches", bits_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/tscs_pkg.sv
hw/rtl/tscs_front.sv
hw/rtl/tscs_queue.sv
hw/rtl/tscs_back.sv
hw/rtl/telemetry_sentence_crc_serializer.sv
verif/tb_telemetry_sentence_crc_serializer.sv
